// ===== rtl/vqdm_pkg.sv =====
// ============================================================================
// Virtqueue descriptor manager package
// Shared types, codes and default sizes for the descriptor manager.
// ============================================================================
package vqdm_pkg;

    localparam int DEF_MAX_QUEUE_SIZE = 256;
    localparam int DEF_QUEUE_COUNT    = 4;
    localparam int NUM_SIZE_REGS      = 4;
    localparam int SIZE_W             = 9;
    localparam logic [15:0] LINK_END  = 16'hFFFF;

    // One descriptor table entry as kept in memory.
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] len;
        logic [1:0]  flags;
        logic [15:0] link;
    } desc_t;

    typedef enum logic [1:0] {
        ACT_SUBMIT   = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_READ     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_DISABLED = 2'd2
    } status_t;

    localparam logic [1:0] FLAG_NEXT  = 2'b01;
    localparam logic [1:0] FLAG_WRITE = 2'b10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_DISP,
        ST_S_RD,
        ST_S_RD2,
        ST_C_CHK,
        ST_C_RD,
        ST_R_RD,
        ST_FIN
    } state_t;

endpackage

// ===== rtl/vqdm_desc_mem.sv =====
// ============================================================================
// Descriptor table memory
// One write port and one read port with registered read data.
// ============================================================================
module vqdm_desc_mem #(
    parameter int Depth = 1024,
    parameter int AddrW = 10
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AddrW-1:0]   wr_addr,
    input  vqdm_pkg::desc_t    wr_data,
    input  logic [AddrW-1:0]   rd_addr,
    output vqdm_pkg::desc_t    rd_data
);
    import vqdm_pkg::*;

    desc_t mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/virtqueue_descriptor_manager.sv =====
// ============================================================================
// Virtqueue descriptor manager
// Driver-side free chain, available counters and descriptor reads for
// several split virtqueues.
// ============================================================================
// One transaction is taken at a time. An item on a disabled queue, or a
// submit refused at dispatch for lack of free descriptors, goes from
// dispatch straight to the final step. A submit reads the free head and
// writes it back filled, and a two-descriptor submit then fills the
// second one unless it lies outside the queue. A read reads the one
// descriptor. A complete reads and writes back each descriptor walked,
// stopping at a link outside the queue or at the size bound.
// The final step waits while the previous result still waits on the
// master side. After reset the whole table is swept once and after a
// size write that queue's MaxQueueSize entries are swept; no transaction
// is taken during a sweep. The next item may enter while a result
// still waits on the master side.
module virtqueue_descriptor_manager #(
    parameter int MaxQueueSize = vqdm_pkg::DEF_MAX_QUEUE_SIZE,
    parameter int QueueCount   = vqdm_pkg::DEF_QUEUE_COUNT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // out_address, out_length, in_address, in_length, desc_index
    input  logic [135:0] s_tdata,
    // action, queue
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // head, avail_slot, avail_count, freed, free_count, used_count,
    // desc_address, desc_length, desc_flags, desc_link, zero pad
    output logic [151:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);
    import vqdm_pkg::*;

    localparam int IW    = (MaxQueueSize > 1) ? $clog2(MaxQueueSize) : 1;
    localparam int QW    = (QueueCount > 1) ? $clog2(QueueCount) : 1;
    localparam int Depth = QueueCount * MaxQueueSize;
    localparam int AW    = $clog2(Depth);

    state_t state_reg, state_next;

    // Per-queue control state.
    logic [SIZE_W-1:0] eff_size_reg [QueueCount];
    logic [SIZE_W-1:0] eff_size_next [QueueCount];
    logic [15:0]       fl_head_reg [QueueCount];
    logic [15:0]       fl_head_next [QueueCount];
    logic [SIZE_W-1:0] free_total_reg [QueueCount];
    logic [SIZE_W-1:0] free_total_next [QueueCount];
    logic [15:0]       avail_reg [QueueCount];
    logic [15:0]       avail_next [QueueCount];
    logic [15:0]       used_reg [QueueCount];
    logic [15:0]       used_next [QueueCount];
    logic [SIZE_W-1:0] slot_reg [QueueCount];
    logic [SIZE_W-1:0] slot_next [QueueCount];

    // Clearing sweep.
    logic [QW-1:0]     clr_q_reg, clr_q_next;
    logic [IW-1:0]     clr_idx_reg, clr_idx_next;
    logic [SIZE_W-1:0] clr_sz_reg, clr_sz_next;
    logic              clr_all_reg, clr_all_next;

    // Item being worked on.
    logic [1:0]  act_reg, act_next;
    logic [1:0]  q_reg, q_next;
    logic [31:0] oa_reg, oa_next, ol_reg, ol_next;
    logic [31:0] ia_reg, ia_next, il_reg, il_next;
    logic [7:0]  di_reg, di_next;
    logic [15:0] cur_reg, cur_next;
    logic [SIZE_W-1:0] steps_reg, steps_next;

    // Pending result.
    logic [1:0]  rs_status_reg, rs_status_next;
    logic [7:0]  rs_head_reg, rs_head_next;
    logic [7:0]  rs_slot_reg, rs_slot_next;
    logic [8:0]  rs_freed_reg, rs_freed_next;
    desc_t       rs_desc_reg, rs_desc_next;

    // Output register.
    logic         m_valid_reg, m_valid_next;
    logic [151:0] m_data_reg, m_data_next;
    logic [1:0]   m_user_reg, m_user_next;

    // Memory ports.
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    desc_t         wr_data, rd_data;

    logic [QW-1:0]     qi;
    logic              present;
    logic [SIZE_W-1:0] sz;
    logic [15:0]       sz16;
    logic              two_part;
    logic [16:0]       clr_nx;
    logic [15:0]       clr_link;

    vqdm_desc_mem #(
        .Depth (Depth),
        .AddrW (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign qi       = QW'(q_reg);
    assign present  = 32'(q_reg) < QueueCount;
    assign sz       = eff_size_reg[qi];
    assign sz16     = 16'(sz);
    assign two_part = il_reg != 32'd0;
    assign clr_nx   = 17'(clr_idx_reg) + 17'd1;
    assign clr_link = (32'(clr_nx) < MaxQueueSize && clr_nx != 17'(clr_sz_reg))
                      ? clr_nx[15:0] : LINK_END;

    // A configuration write has priority, so the input waits while one is offered.
    assign s_tready  = state_reg == ST_IDLE && !cfg_valid;
    assign cfg_ready = state_reg == ST_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_comb begin
        state_next      = state_reg;
        eff_size_next   = eff_size_reg;
        fl_head_next    = fl_head_reg;
        free_total_next = free_total_reg;
        avail_next      = avail_reg;
        used_next       = used_reg;
        slot_next       = slot_reg;
        clr_q_next      = clr_q_reg;
        clr_idx_next    = clr_idx_reg;
        clr_sz_next     = clr_sz_reg;
        clr_all_next    = clr_all_reg;
        act_next        = act_reg;
        q_next          = q_reg;
        oa_next         = oa_reg;
        ol_next         = ol_reg;
        ia_next         = ia_reg;
        il_next         = il_reg;
        di_next         = di_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        rs_status_next  = rs_status_reg;
        rs_head_next    = rs_head_reg;
        rs_slot_next    = rs_slot_reg;
        rs_freed_next   = rs_freed_reg;
        rs_desc_next    = rs_desc_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    if (32'(cfg_index) < QueueCount) begin
                        logic [QW-1:0]     ci;
                        logic [SIZE_W-1:0] es;
                        ci = QW'(cfg_index);
                        es = (32'(cfg_data) > MaxQueueSize) ? SIZE_W'(MaxQueueSize)
                                                            : cfg_data;
                        eff_size_next[ci]   = es;
                        fl_head_next[ci]    = 16'd0;
                        free_total_next[ci] = es;
                        avail_next[ci]      = 16'd0;
                        used_next[ci]       = 16'd0;
                        slot_next[ci]       = '0;
                        clr_q_next          = ci;
                        clr_sz_next         = es;
                        clr_idx_next        = '0;
                        clr_all_next        = 1'b0;
                        state_next          = ST_CLR;
                    end
                end else if (s_tvalid) begin
                    act_next       = s_tuser[1:0];
                    q_next         = s_tuser[3:2];
                    oa_next        = s_tdata[31:0];
                    ol_next        = s_tdata[63:32];
                    ia_next        = s_tdata[95:64];
                    il_next        = s_tdata[127:96];
                    di_next        = s_tdata[135:128];
                    rs_status_next = STAT_OK;
                    rs_head_next   = 8'd0;
                    rs_slot_next   = 8'd0;
                    rs_freed_next  = 9'd0;
                    rs_desc_next   = '{addr: 32'd0, len: 32'd0, flags: 2'd0,
                                       link: LINK_END};
                    state_next     = ST_DISP;
                end
            end

            ST_CLR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(32'(clr_q_reg) * MaxQueueSize + 32'(clr_idx_reg));
                wr_data = '{addr: 32'd0, len: 32'd0, flags: 2'd0, link: clr_link};
                if (32'(clr_idx_reg) == MaxQueueSize - 1) begin
                    clr_idx_next = '0;
                    if (clr_all_reg && 32'(clr_q_reg) != QueueCount - 1) begin
                        clr_q_next = clr_q_reg + QW'(1);
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    clr_idx_next = clr_idx_reg + IW'(1);
                end
            end

            ST_DISP: begin
                state_next = ST_FIN;
                if (!present) begin
                    rs_status_next = STAT_DISABLED;
                end else if (sz == '0) begin
                    rs_status_next = (act_reg == ACT_NONE) ? STAT_OK : STAT_DISABLED;
                end else begin
                    case (act_reg)
                        ACT_SUBMIT: begin
                            logic [SIZE_W-1:0] need;
                            need = two_part ? SIZE_W'(2) : SIZE_W'(1);
                            if (free_total_reg[qi] >= need && fl_head_reg[qi] < sz16)
                            begin
                                cur_next   = fl_head_reg[qi];
                                rd_addr    = AW'(32'(qi) * MaxQueueSize
                                                 + 32'(fl_head_reg[qi][IW-1:0]));
                                state_next = ST_S_RD;
                            end else begin
                                rs_status_next = STAT_FULL;
                            end
                        end
                        ACT_COMPLETE: begin
                            used_next[qi] = used_reg[qi] + 16'd1;
                            cur_next      = 16'(di_reg);
                            steps_next    = '0;
                            state_next    = ST_C_CHK;
                        end
                        ACT_READ: begin
                            if (32'(di_reg) < MaxQueueSize) begin
                                rd_addr    = AW'(32'(qi) * MaxQueueSize
                                                 + 32'(IW'(di_reg)));
                                state_next = ST_R_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_S_RD: begin
                if (two_part) begin
                    if (rd_data.link < sz16) begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(32'(qi) * MaxQueueSize + 32'(cur_reg[IW-1:0]));
                        wr_data    = '{addr: oa_reg, len: ol_reg, flags: FLAG_NEXT,
                                       link: rd_data.link};
                        rd_addr    = AW'(32'(qi) * MaxQueueSize
                                         + 32'(rd_data.link[IW-1:0]));
                        state_next = ST_S_RD2;
                    end else begin
                        rs_status_next = STAT_FULL;
                        state_next     = ST_FIN;
                    end
                end else begin
                    wr_en               = 1'b1;
                    wr_addr             = AW'(32'(qi) * MaxQueueSize
                                              + 32'(cur_reg[IW-1:0]));
                    wr_data             = '{addr: oa_reg, len: ol_reg, flags: 2'd0,
                                            link: rd_data.link};
                    fl_head_next[qi]    = rd_data.link;
                    free_total_next[qi] = free_total_reg[qi] - SIZE_W'(1);
                    state_next          = ST_FIN;
                end
                // The head goes out once the submit is certain to succeed.
                if (!two_part || rd_data.link < sz16) begin
                    rs_head_next  = cur_reg[7:0];
                    rs_slot_next  = slot_reg[qi][7:0];
                    avail_next[qi] = avail_reg[qi] + 16'd1;
                    // The slot tracks avail_count modulo the size, and the
                    // 16-bit counter wrap sends it back to zero.
                    if (avail_reg[qi] == 16'hFFFF || slot_reg[qi] + SIZE_W'(1) == sz) begin
                        slot_next[qi] = '0;
                    end else begin
                        slot_next[qi] = slot_reg[qi] + SIZE_W'(1);
                    end
                    if (two_part) begin
                        cur_next = rd_data.link;
                    end
                end
            end

            ST_S_RD2: begin
                wr_en               = 1'b1;
                wr_addr             = AW'(32'(qi) * MaxQueueSize + 32'(cur_reg[IW-1:0]));
                wr_data             = '{addr: ia_reg, len: il_reg, flags: FLAG_WRITE,
                                        link: rd_data.link};
                fl_head_next[qi]    = rd_data.link;
                free_total_next[qi] = free_total_reg[qi] - SIZE_W'(2);
                state_next          = ST_FIN;
            end

            ST_C_CHK: begin
                if (cur_reg < sz16 && steps_reg < sz) begin
                    rd_addr    = AW'(32'(qi) * MaxQueueSize + 32'(cur_reg[IW-1:0]));
                    state_next = ST_C_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_C_RD: begin
                wr_en            = 1'b1;
                wr_addr          = AW'(32'(qi) * MaxQueueSize + 32'(cur_reg[IW-1:0]));
                wr_data          = '{addr: rd_data.addr, len: rd_data.len,
                                     flags: rd_data.flags, link: fl_head_reg[qi]};
                fl_head_next[qi] = cur_reg;
                if (free_total_reg[qi] < sz) begin
                    free_total_next[qi] = free_total_reg[qi] + SIZE_W'(1);
                end
                steps_next    = steps_reg + SIZE_W'(1);
                rs_freed_next = steps_reg + SIZE_W'(1);
                if (rd_data.flags[0]) begin
                    cur_next   = rd_data.link;
                    state_next = ST_C_CHK;
                end else begin
                    state_next = ST_FIN;
                end
            end

            ST_R_RD: begin
                rs_desc_next = rd_data;
                state_next   = ST_FIN;
            end

            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next        = 1'b1;
                    m_user_next         = rs_status_reg;
                    m_data_next         = '0;
                    m_data_next[7:0]    = rs_head_reg;
                    m_data_next[15:8]   = rs_slot_reg;
                    m_data_next[40:32]  = rs_freed_reg;
                    if (present) begin
                        m_data_next[31:16] = avail_reg[qi];
                        m_data_next[49:41] = free_total_reg[qi];
                        m_data_next[65:50] = used_reg[qi];
                    end
                    m_data_next[97:66]   = rs_desc_reg.addr;
                    m_data_next[129:98]  = rs_desc_reg.len;
                    m_data_next[131:130] = rs_desc_reg.flags;
                    m_data_next[147:132] = rs_desc_reg.link;
                    state_next           = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            eff_size_reg   <= '{default: '0};
            fl_head_reg    <= '{default: '0};
            free_total_reg <= '{default: '0};
            avail_reg      <= '{default: '0};
            used_reg       <= '{default: '0};
            slot_reg       <= '{default: '0};
            clr_q_reg      <= '0;
            clr_idx_reg    <= '0;
            clr_sz_reg     <= '0;
            clr_all_reg    <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            eff_size_reg   <= eff_size_next;
            fl_head_reg    <= fl_head_next;
            free_total_reg <= free_total_next;
            avail_reg      <= avail_next;
            used_reg       <= used_next;
            slot_reg       <= slot_next;
            clr_q_reg      <= clr_q_next;
            clr_idx_reg    <= clr_idx_next;
            clr_sz_reg     <= clr_sz_next;
            clr_all_reg    <= clr_all_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        q_reg         <= q_next;
        oa_reg        <= oa_next;
        ol_reg        <= ol_next;
        ia_reg        <= ia_next;
        il_reg        <= il_next;
        di_reg        <= di_next;
        cur_reg       <= cur_next;
        steps_reg     <= steps_next;
        rs_status_reg <= rs_status_next;
        rs_head_reg   <= rs_head_next;
        rs_slot_reg   <= rs_slot_next;
        rs_freed_reg  <= rs_freed_next;
        rs_desc_reg   <= rs_desc_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    // An accepted transaction always starts at dispatch.
    a_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !cfg_valid) |=> state_reg == ST_DISP)
        else $error("accepted transaction did not reach dispatch");

    // The descriptor memory is never written between transactions.
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_FIN) |-> !wr_en)
        else $error("descriptor write outside an item or sweep");

    // A chain walk never frees more descriptors than the queue holds.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C_CHK) |-> steps_reg <= sz)
        else $error("chain walk ran past the queue size");

    // The free total stays within the queue size.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && present) |-> free_total_reg[qi] <= sz)
        else $error("free total above queue size");

endmodule

// ===== dv/virtqueue_descriptor_manager_tb.sv =====
// ============================================================================
// Virtqueue descriptor manager testbench
// Drives submit, complete, read and unused-action transactions with random
// idling on both streams, checks every result against an in-bench model of
// the queues, and resizes the queues between phases.
// ============================================================================
module virtqueue_descriptor_manager_tb;
    import vqdm_pkg::*;

    localparam int QSIZE     = DEF_MAX_QUEUE_SIZE;
    localparam int NQ        = DEF_QUEUE_COUNT;
    localparam int NUM_PHASE = 6;
    localparam int PHASE_LEN = 150;
    localparam int STALL_MAX = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  head;
        logic [7:0]  slot;
        logic [15:0] avail_cnt;
        logic [8:0]  freed;
        logic [8:0]  free_cnt;
        logic [15:0] used_cnt;
        logic [31:0] d_addr;
        logic [31:0] d_len;
        logic [1:0]  d_flags;
        logic [15:0] d_link;
    } vq_result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        action_t     act;
        logic [1:0]  q;
        logic [31:0] oa;
        logic [31:0] ol;
        logic [31:0] ia;
        logic [31:0] il;
        logic [7:0]  di;
        bit          typed;
        status_t     t_status;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [3:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [8:0]   cfg_data;

    // Model of the queues.
    logic [31:0] addr_mem [NQ][QSIZE];
    logic [31:0] len_mem  [NQ][QSIZE];
    logic [1:0]  flag_mem [NQ][QSIZE];
    logic [15:0] link_mem [NQ][QSIZE];
    bit          written  [NQ][QSIZE];
    logic [15:0] fl_head   [NQ];
    int          free_total[NQ];
    logic [15:0] avail_ctr [NQ];
    logic [15:0] used_ctr  [NQ];
    logic [8:0]  size_reg  [NQ];
    int          pending_heads[NQ][$];

    vq_result_t expected_results[$];
    int         mismatches;
    int         results_seen;
    int         idle_cycles;
    bit         no_idle;
    dir_row_t   dir[$];

    virtqueue_descriptor_manager DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int eff_size(int q);
        return (size_reg[q] > QSIZE) ? QSIZE : int'(size_reg[q]);
    endfunction

    function automatic void rebuild_queue(int q);
        int sz;
        sz = eff_size(q);
        for (int i = 0; i < QSIZE; i++) begin
            addr_mem[q][i] = '0;
            len_mem[q][i]  = '0;
            flag_mem[q][i] = '0;
            written[q][i]  = 1'b0;
            link_mem[q][i] = (i + 1 < QSIZE && i + 1 != sz) ? 16'(i + 1) : LINK_END;
        end
        fl_head[q]    = '0;
        free_total[q] = sz;
        avail_ctr[q]  = '0;
        used_ctr[q]   = '0;
        pending_heads[q].delete();
    endfunction

    // Applies one transaction to the queue model and returns its result.
    function automatic vq_result_t apply_item(action_t act, int q, logic [31:0] oa,
                                              logic [31:0] ol, logic [31:0] ia,
                                              logic [31:0] il, int di);
        vq_result_t r;
        int sz, need, h, n, steps, nx, slot;
        bit ok, more;
        r = '0;
        r.d_link = LINK_END;
        sz = eff_size(q);
        if (sz == 0) begin
            if (act != ACT_NONE) r.status = STAT_DISABLED;
        end else if (act == ACT_SUBMIT) begin
            need = (il != 0) ? 2 : 1;
            h = fl_head[q];
            n = 0;
            ok = free_total[q] >= need && h < sz;
            if (ok && need == 2) begin
                n = link_mem[q][h];
                ok = n < sz;
            end
            if (!ok) begin
                r.status = STAT_FULL;
            end else begin
                addr_mem[q][h] = oa;
                len_mem[q][h]  = ol;
                flag_mem[q][h] = (need == 2) ? FLAG_NEXT : 2'b00;
                written[q][h]  = 1'b1;
                if (need == 2) begin
                    addr_mem[q][n] = ia;
                    len_mem[q][n]  = il;
                    flag_mem[q][n] = FLAG_WRITE;
                    written[q][n]  = 1'b1;
                    fl_head[q]     = link_mem[q][n];
                end else begin
                    fl_head[q] = link_mem[q][h];
                end
                free_total[q] -= need;
                slot = avail_ctr[q] % sz;
                avail_ctr[q] += 16'd1;
                r.head = 8'(h);
                r.slot = 8'(slot);
                pending_heads[q].push_back(h);
            end
        end else if (act == ACT_COMPLETE) begin
            steps = 0;
            while (di < sz && steps < sz) begin
                nx   = link_mem[q][di];
                more = flag_mem[q][di][0];
                link_mem[q][di] = fl_head[q];
                fl_head[q] = 16'(di);
                if (free_total[q] < sz) free_total[q]++;
                steps++;
                if (!more) break;
                di = nx;
            end
            used_ctr[q] += 16'd1;
            r.freed = 9'(steps);
        end else if (act == ACT_READ) begin
            r.d_addr  = addr_mem[q][di];
            r.d_len   = len_mem[q][di];
            r.d_flags = flag_mem[q][di];
            r.d_link  = link_mem[q][di];
        end
        r.avail_cnt = avail_ctr[q];
        r.free_cnt  = 9'(free_total[q]);
        r.used_cnt  = used_ctr[q];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_seen, field, got, exp_val);
        mismatches++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        vq_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status    = m_tuser;
            got.head      = m_tdata[7:0];
            got.slot      = m_tdata[15:8];
            got.avail_cnt = m_tdata[31:16];
            got.freed     = m_tdata[40:32];
            got.free_cnt  = m_tdata[49:41];
            got.used_cnt  = m_tdata[65:50];
            got.d_addr    = m_tdata[97:66];
            got.d_len     = m_tdata[129:98];
            got.d_flags   = m_tdata[131:130];
            got.d_link    = m_tdata[147:132];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.head != want.head) report_mismatch("head", got.head, want.head);
                if (got.slot != want.slot)
                    report_mismatch("avail_slot", got.slot, want.slot);
                if (got.avail_cnt != want.avail_cnt)
                    report_mismatch("avail_count", got.avail_cnt, want.avail_cnt);
                if (got.freed != want.freed) report_mismatch("freed", got.freed, want.freed);
                if (got.free_cnt != want.free_cnt)
                    report_mismatch("free_count", got.free_cnt, want.free_cnt);
                if (got.used_cnt != want.used_cnt)
                    report_mismatch("used_count", got.used_cnt, want.used_cnt);
                if (got.d_addr != want.d_addr)
                    report_mismatch("desc_address", got.d_addr, want.d_addr);
                if (got.d_len != want.d_len)
                    report_mismatch("desc_length", got.d_len, want.d_len);
                if (got.d_flags != want.d_flags)
                    report_mismatch("desc_flags", got.d_flags, want.d_flags);
                if (got.d_link != want.d_link)
                    report_mismatch("desc_link", got.d_link, want.d_link);
            end
            results_seen++;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        bit held;
        int gap;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = pick_gap();
            if (!held && results_seen >= 300) begin
                held = 1'b1;
                gap = 400;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic write_size(int q, logic [8:0] sz);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= 2'(q);
        cfg_data  <= sz;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg[q] = sz;
        rebuild_queue(q);
        @(posedge aclk);
    endtask

    // Offers one transaction and returns right after it is accepted; the
    // valid stays high so a back-to-back item follows without a gap.
    task automatic send_item(action_t act, int q, logic [31:0] oa, logic [31:0] ol,
                             logic [31:0] ia, logic [31:0] il, int di);
        s_tvalid <= 1'b1;
        s_tuser  <= {2'(q), act};
        s_tdata  <= {8'(di), il, ia, ol, oa};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [8:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 9'd0;
        if (r < 80) return 9'($urandom_range(1, 8));
        if (r < 87) return 9'd256;
        if (r < 93) return 9'd511;
        return 9'($urandom_range(9, 300));
    endfunction

    function automatic void add_row(row_kind_t kind, action_t act, int q, logic [31:0] oa,
                                    logic [31:0] ol, logic [31:0] ia, logic [31:0] il,
                                    int di, bit typed, status_t st);
        dir_row_t row;
        row = '{kind, act, 2'(q), oa, ol, ia, il, 8'(di), typed, st};
        dir.push_back(row);
    endfunction

    initial begin
        vq_result_t r;
        action_t act;
        int q, di, pick, k;
        int idx_list[$];
        logic [31:0] oa, ol, ia, il;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        for (int i = 0; i < NQ; i++) begin
            size_reg[i] = '0;
            rebuild_queue(i);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; every queue starts disabled.
        add_row(ROW_ITEM, ACT_SUBMIT, 0, 32'hFFFF_FFFF, 1, 0, 5, 0, 1, STAT_DISABLED);
        add_row(ROW_ITEM, ACT_COMPLETE, 1, 0, 0, 0, 0, 0, 1, STAT_DISABLED);
        add_row(ROW_ITEM, ACT_READ, 2, 0, 0, 0, 0, 255, 1, STAT_DISABLED);
        add_row(ROW_ITEM, ACT_NONE, 3, 0, 0, 0, 0, 0, 1, STAT_OK);
        add_row(ROW_CFG, ACT_NONE, 0, 0, 1, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_CFG, ACT_NONE, 1, 0, 2, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_CFG, ACT_NONE, 2, 0, 256, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_CFG, ACT_NONE, 3, 0, 511, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 0, 32'hFFFF_FFFF, 32'h1234, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 0, 1, 2, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_READ, 0, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_COMPLETE, 0, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 0, 5, 6, 7, 8, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_COMPLETE, 0, 0, 0, 0, 0, 200, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_READ, 1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_READ, 1, 0, 0, 0, 0, 1, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_COMPLETE, 1, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_READ, 2, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_NONE, 2, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 3, 11, 22, 33, 44, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_COMPLETE, 3, 0, 0, 0, 0, 255, 0, STAT_OK);
        add_row(ROW_CFG, ACT_NONE, 3, 0, 0, 0, 0, 0, 0, STAT_OK);
        add_row(ROW_ITEM, ACT_SUBMIT, 3, 1, 1, 1, 1, 0, 1, STAT_DISABLED);

        foreach (dir[i]) begin
            if (dir[i].kind == ROW_CFG) begin
                s_tvalid <= 1'b0;
                write_size(dir[i].q, 9'(dir[i].ol));
            end else begin
                r = apply_item(dir[i].act, dir[i].q, dir[i].oa, dir[i].ol, dir[i].ia,
                               dir[i].il, dir[i].di);
                if (dir[i].typed) begin
                    r = '0;
                    r.status = dir[i].t_status;
                    r.d_link = LINK_END;
                end
                expected_results.push_back(r);
                send_item(dir[i].act, dir[i].q, dir[i].oa, dir[i].ol, dir[i].ia,
                          dir[i].il, dir[i].di);
                idle_sender();
            end
        end

        for (int ph = 0; ph < NUM_PHASE; ph++) begin
            s_tvalid <= 1'b0;
            for (int i = 0; i < NQ; i++) write_size(i, pick_size());
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                q  = $urandom_range(0, NQ - 1);
                oa = $urandom;
                ol = $urandom;
                ia = $urandom;
                il = ($urandom_range(0, 9) < 4) ? 32'd0 : $urandom;
                di = $urandom_range(0, 255);
                if (pick < 45) act = ACT_SUBMIT;
                else if (pick < 78) act = ACT_COMPLETE;
                else if (pick < 95) act = ACT_READ;
                else act = ACT_NONE;
                // Mostly complete chains that were really handed out.
                if (act == ACT_COMPLETE && pending_heads[q].size() > 0
                        && $urandom_range(0, 9) < 8) begin
                    k = $urandom_range(0, pending_heads[q].size() - 1);
                    di = pending_heads[q][k];
                    pending_heads[q].delete(k);
                end
                // Reads only touch descriptors that were filled since the last resize.
                if (act == ACT_READ && eff_size(q) > 0) begin
                    idx_list.delete();
                    for (int i = 0; i < QSIZE; i++) if (written[q][i]) idx_list.push_back(i);
                    if (idx_list.size() == 0) act = ACT_SUBMIT;
                    else di = idx_list[$urandom_range(0, idx_list.size() - 1)];
                end
                r = apply_item(act, q, oa, ol, ia, il, di);
                expected_results.push_back(r);
                send_item(act, q, oa, ol, ia, il, di);
                idle_sender();
            end
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
